// ----- design/touch_point_jump_filter_defines.svh -----
// Assertion macros used by the touch point jump filter top level.
`ifndef TOUCH_POINT_JUMP_FILTER_DEFINES_SVH
`define TOUCH_POINT_JUMP_FILTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TPJF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpjf check failed");

// Next-cycle implication, checked out of reset.
`define TPJF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpjf check failed");

`endif

// ----- design/tpjf_pkg.sv -----
// Shared constants and types of the touch point jump filter.
`timescale 1ns / 1ps
`default_nettype none

package tpjf_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int CMP_W      = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

    localparam logic [FIELD_W-1:0] SENTINEL     = 16'd10000;
    localparam logic [FIELD_W-1:0] THRESH_RESET = 16'd300;

    // Event kinds carried in tuser
    localparam logic [1:0] OP_OTHER = 2'd0;
    localparam logic [1:0] OP_X     = 2'd1;
    localparam logic [1:0] OP_Y     = 2'd2;
    localparam logic [1:0] OP_MARK  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0]            op;
        logic [COORD_BITS-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic hold;
        logic jumped_x;
        logic jumped_y;
    } t_track_stat;

endpackage

`default_nettype wire

// ----- design/tpjf_front.sv -----
// Input side: accept stream words and drop those that carry no work.
`timescale 1ns / 1ps
`default_nettype none

module tpjf_front (
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [1:0]                 s_axis_tuser,  // op
    input  wire logic [15:0]                s_axis_tdata,  // axis_value
    input  wire logic                       i_capture_en,
    input  wire tpjf_pkg::t_q_stat          i_q_stat,
    output logic                            o_push,
    output tpjf_pkg::t_cmd                  o_cmd
);
    import tpjf_pkg::*;

    logic w_keep;

    assign s_axis_tready = !i_q_stat.full;

    // Drop everything while capture is off, and other events always
    assign w_keep = i_capture_en && (s_axis_tuser != OP_OTHER);
    assign o_push = s_axis_tvalid && s_axis_tready && w_keep;

    assign o_cmd.op    = s_axis_tuser;
    assign o_cmd.value = COORD_BITS'(s_axis_tdata);

endmodule

`default_nettype wire

// ----- design/tpjf_queue.sv -----
// Short command queue between the input side and the tracker.
`timescale 1ns / 1ps
`default_nettype none

module tpjf_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire tpjf_pkg::t_cmd     i_cmd,
    input  wire logic               i_pop,
    output tpjf_pkg::t_cmd          o_cmd,
    output tpjf_pkg::t_q_stat       o_stat
);
    import tpjf_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count, n_count;
    logic            w_push, w_pop;

    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_cmd  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- design/tpjf_back.sv -----
// Tracker: axis state, jump detection, emission and the output register.
`timescale 1ns / 1ps
`default_nettype none

module tpjf_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tpjf_pkg::t_cmd             i_cmd,
    input  wire tpjf_pkg::t_q_stat          i_q_stat,
    output logic                            o_pop,
    input  wire logic [15:0]                i_threshold,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // point_x, point_y
    output logic                            m_axis_tuser,  // is_reset_marker
    output tpjf_pkg::t_track_stat           o_track
);
    import tpjf_pkg::*;

    logic [COORD_BITS-1:0] r_last_x, n_last_x;
    logic [COORD_BITS-1:0] r_last_y, n_last_y;
    logic                  r_x_seen, n_x_seen;
    logic                  r_y_seen, n_y_seen;
    logic                  r_fresh_x, n_fresh_x;
    logic                  r_fresh_y, n_fresh_y;
    logic                  r_jumped_x, n_jumped_x;
    logic                  r_jumped_y, n_jumped_y;
    logic                  r_hold, n_hold;

    logic                  r_out_valid, n_out_valid;
    logic [FIELD_W-1:0]    r_out_x, n_out_x;
    logic [FIELD_W-1:0]    r_out_y, n_out_y;
    logic                  r_out_mark, n_out_mark;

    logic [COORD_BITS-1:0] w_sel_last;
    logic                  w_sel_seen;
    logic [COORD_BITS-1:0] w_diff;
    logic                  w_changed;
    logic                  w_jump;
    logic                  w_emit;

    // Advance the queue whenever the output slot is free or draining
    assign o_pop = !i_q_stat.empty && (!r_out_valid || m_axis_tready);

    assign w_sel_last = (i_cmd.op == OP_X) ? r_last_x : r_last_y;
    assign w_sel_seen = (i_cmd.op == OP_X) ? r_x_seen : r_y_seen;
    assign w_diff     = (w_sel_last > i_cmd.value) ? (w_sel_last - i_cmd.value)
                                                   : (i_cmd.value - w_sel_last);
    assign w_changed  = !w_sel_seen || (w_sel_last != i_cmd.value);
    assign w_jump     = w_sel_seen && (CMP_W'(w_diff) > CMP_W'(i_threshold));

    always_comb begin
        n_last_x   = r_last_x;
        n_last_y   = r_last_y;
        n_x_seen   = r_x_seen;
        n_y_seen   = r_y_seen;
        n_fresh_x  = r_fresh_x;
        n_fresh_y  = r_fresh_y;
        n_jumped_x = r_jumped_x;
        n_jumped_y = r_jumped_y;
        n_hold     = r_hold;
        w_emit     = 1'b0;
        n_out_x    = r_out_x;
        n_out_y    = r_out_y;
        n_out_mark = r_out_mark;

        if (o_pop) begin
            unique case (i_cmd.op)
                OP_MARK: begin
                    w_emit     = 1'b1;
                    n_out_x    = FIELD_W'(COORD_BITS'(SENTINEL));
                    n_out_y    = FIELD_W'(COORD_BITS'(SENTINEL));
                    n_out_mark = 1'b1;
                end
                OP_X, OP_Y: begin
                    if (w_changed) begin
                        if (i_cmd.op == OP_X) begin
                            n_last_x  = i_cmd.value;
                            n_x_seen  = 1'b1;
                            n_fresh_x = 1'b1;
                            if (w_jump) begin
                                n_jumped_x = 1'b1;
                            end
                        end else begin
                            n_last_y  = i_cmd.value;
                            n_y_seen  = 1'b1;
                            n_fresh_y = 1'b1;
                            if (w_jump) begin
                                n_jumped_y = 1'b1;
                            end
                        end
                    end
                    if (n_fresh_x && n_fresh_y) begin
                        if (n_jumped_x || n_jumped_y) begin
                            // After a jump, arm first and emit on the next qualifying word
                            if (!r_hold) begin
                                n_hold = 1'b1;
                            end else begin
                                w_emit     = 1'b1;
                                n_fresh_x  = 1'b0;
                                n_fresh_y  = 1'b0;
                                n_jumped_x = 1'b0;
                                n_jumped_y = 1'b0;
                                n_hold     = 1'b0;
                            end
                        end else begin
                            w_emit    = 1'b1;
                            n_fresh_x = 1'b0;
                            n_fresh_y = 1'b0;
                        end
                    end
                    if (w_emit) begin
                        n_out_x    = FIELD_W'(n_last_x);
                        n_out_y    = FIELD_W'(n_last_y);
                        n_out_mark = 1'b0;
                    end
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_x_seen    <= 1'b0;
            r_y_seen    <= 1'b0;
            r_fresh_x   <= 1'b0;
            r_fresh_y   <= 1'b0;
            r_jumped_x  <= 1'b0;
            r_jumped_y  <= 1'b0;
            r_hold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
            r_x_seen    <= n_x_seen;
            r_y_seen    <= n_y_seen;
            r_fresh_x   <= n_fresh_x;
            r_fresh_y   <= n_fresh_y;
            r_jumped_x  <= n_jumped_x;
            r_jumped_y  <= n_jumped_y;
            r_hold      <= n_hold;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_mark <= n_out_mark;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_mark;

    assign o_track.hold     = r_hold;
    assign o_track.jumped_x = r_jumped_x;
    assign o_track.jumped_y = r_jumped_y;

endmodule

`default_nettype wire

// ----- design/touch_point_jump_filter.sv -----
// Touch point jump filter: top level with configuration registers.
//
// Input stream (s_axis): one word per touchpad event; tuser carries the
// event kind (other, X axis, Y axis, reset marker), tdata the coordinate.
// Output stream (m_axis): one word per emitted point; tdata holds X in the
// low half and Y in the high half, tuser flags the reset sentinel point
// (10000, 10000). Many input words produce no output word.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0: capture enable, 1: jump threshold); write only while idle.
// Throughput: one input word per cycle while the output is not stalled;
// an accepted word is written into the queue, then the tracker registers its result.
// A two-entry command queue sits between the input side and the tracker,
// and a registered output slot follows the tracker. When the receiver
// stalls, the slot holds its word, the tracker stops, the queue fills and
// then s_axis_tready drops.
// Reset (synchronous, active low) clears all tracking flags, empties the
// queue and the output slot, turns capture off and loads a threshold of 300.
`timescale 1ns / 1ps
`default_nettype none

`include "touch_point_jump_filter_defines.svh"

module touch_point_jump_filter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [1:0]                     s_axis_tuser,  // op
    input  wire logic [15:0]                    s_axis_tdata,  // axis_value
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // point_x, point_y
    output logic                                m_axis_tuser,  // is_reset_marker
    input  wire logic                           i_cfg_we,
    input  wire logic [tpjf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tpjf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tpjf_pkg::*;

    logic        r_capture_en;
    logic [15:0] r_threshold;

    logic        w_push;
    logic        w_pop;
    t_cmd        w_in_cmd;
    t_cmd        w_q_cmd;
    t_q_stat     w_q_stat;
    t_track_stat w_track;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_en <= 1'b0;
            r_threshold  <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CAPTURE: r_capture_en <= i_cfg_data[0];
                REG_THRESH:  r_threshold  <= i_cfg_data[15:0];
                default:     r_capture_en <= r_capture_en;
            endcase
        end
    end

    tpjf_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .i_capture_en  (r_capture_en),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_cmd         (w_in_cmd)
    );

    tpjf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    tpjf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_q_cmd),
        .i_q_stat      (w_q_stat),
        .o_pop         (w_pop),
        .i_threshold   (r_threshold),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_track       (w_track)
    );

    // Sentinel words always carry the sentinel coordinates
    `TPJF_ASSERT_NOW(a_sentinel_point, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[15:0] == FIELD_W'(COORD_BITS'(SENTINEL))) && (m_axis_tdata[31:16] == FIELD_W'(COORD_BITS'(SENTINEL))))
    // Delayed emission is armed only behind a pending jump
    `TPJF_ASSERT_NOW(a_hold_needs_jump, i_clk, i_rst_n, w_track.hold, w_track.jumped_x || w_track.jumped_y)
    // No output word appears without queued work
    `TPJF_ASSERT_NEXT(a_no_spurious_out, i_clk, i_rst_n, w_q_stat.empty && !m_axis_tvalid, !m_axis_tvalid)
    // Dropped words never enter the queue
    `TPJF_ASSERT_NOW(a_drop_other, i_clk, i_rst_n, (s_axis_tuser == OP_OTHER) || !r_capture_en, !w_push)

endmodule

`default_nettype wire

// ----- dv/tb_touch_point_jump_filter.sv -----
// Testbench for the touch point jump filter: streamed axis events against a point predictor.
`timescale 1ns / 1ps

module tb_touch_point_jump_filter;
    import tpjf_pkg::*;

    localparam int IDLE_PCT      = 14;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        mark;
    } t_point;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [1:0]            s_axis_tuser  = OP_OTHER;
    logic [15:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = REG_CAPTURE;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Predicted tracker state; index 0 is the X axis, index 1 the Y axis
    logic              en_capture = 1'b0;
    logic [15:0]       thresh     = THRESH_RESET;
    logic [1:0][15:0]  pos        = '0;
    logic [1:0]        has        = '0;
    logic [1:0]        new_flag   = '0;
    logic [1:0]        jump       = '0;
    logic              armed      = 1'b0;

    t_point points_due[$];
    int     mismatches    = 0;
    int     counted_items = 0;
    bit     gaps_off      = 1'b0;

    touch_point_jump_filter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Update the tracker for one accepted event and queue the point it emits.
    function automatic void track_event(logic [1:0] op, logic [15:0] v);
        t_point      p;
        int          a;
        logic [15:0] d;
        if (!en_capture || op == OP_OTHER)
            return;
        if (op == OP_MARK) begin
            p.x    = SENTINEL;
            p.y    = SENTINEL;
            p.mark = 1'b1;
            points_due.insert(points_due.size(), p);
            return;
        end
        a = (op == OP_X) ? 0 : 1;
        if (!has[a] || pos[a] != v) begin
            if (has[a]) begin
                d = (pos[a] > v) ? pos[a] - v : v - pos[a];
                if (d > thresh)
                    jump[a] = 1'b1;
            end
            pos[a]      = v;
            has[a]      = 1'b1;
            new_flag[a] = 1'b1;
        end
        if (!(new_flag[0] && new_flag[1]))
            return;
        if (jump != 2'b00) begin
            // first qualifying event after a jump only arms the delayed emit
            if (!armed) begin
                armed = 1'b1;
                return;
            end
            jump  = 2'b00;
            armed = 1'b0;
        end
        new_flag = 2'b00;
        p.x      = pos[0];
        p.y      = pos[1];
        p.mark   = 1'b0;
        points_due.insert(points_due.size(), p);
    endfunction

    // Pick a coordinate near the stored one, often straddling the threshold.
    function automatic logic [15:0] pick_coord(int a);
        int          r;
        int          span;
        int          v;
        logic [15:0] res;
        r = $urandom_range(99);
        if (r < 10)
            return pos[a];
        if (r < 30) begin
            res = 16'($urandom_range(65535));
            return res;
        end
        span = int'(thresh) + int'(thresh) / 4 + 2;
        v    = $urandom_range(span);
        v    = $urandom_range(1) ? int'(pos[a]) + v : int'(pos[a]) - v;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        res = v[15:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : check_points
        t_point want;
        m_axis_tready <= gaps_off ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (points_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected point: x=%0d y=%0d mark=%0b",
                             m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
            end else begin
                want = points_due.pop_front();
                if (m_axis_tdata[15:0] !== want.x || m_axis_tdata[31:16] !== want.y ||
                    m_axis_tuser !== want.mark) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("point mismatch: exp x=%0d y=%0d mark=%0b, got x=%0d y=%0d mark=%0b",
                                 want.x, want.y, want.mark,
                                 m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
                end
            end
        end
    end

    task automatic send_event(input logic [1:0] op, input logic [15:0] v);
        if (!gaps_off && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= v;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (en_capture && op != OP_OTHER)
            counted_items++;
        track_event(op, v);
    endtask

    // Hold off the sender until every predicted point has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (points_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CAPTURE)
            en_capture = data[0];
        else
            thresh = data;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic capture, input logic [15:0] thr);
        wait_drained();
        write_reg(REG_CAPTURE, {15'd0, capture});
        write_reg(REG_THRESH, thr);
    endtask

    // Mostly X/Y pairs in either order; some lone axes, markers and other events.
    task automatic run_random(input int count);
        int stop_at;
        int r;
        int a;
        logic [15:0] junk;
        stop_at = counted_items + count;
        while (counted_items < stop_at) begin
            r    = $urandom_range(99);
            a    = $urandom_range(1);
            junk = 16'($urandom_range(65535));
            if (r < 85) begin
                send_event(a ? OP_Y : OP_X, pick_coord(a));
                send_event(a ? OP_X : OP_Y, pick_coord(1 - a));
            end else if (r < 90) begin
                send_event(OP_OTHER, junk);
            end else if (r < 94) begin
                send_event(OP_MARK, junk);
            end else begin
                send_event(a ? OP_Y : OP_X, pick_coord(a));
            end
        end
    endtask

    // Capture is off out of reset: everything, the marker too, is dropped.
    task automatic test_reset_defaults();
        send_event(OP_MARK, 16'h0000);
        send_event(OP_X, 16'd100);
        send_event(OP_Y, 16'd200);
        send_event(OP_OTHER, 16'hFFFF);
        wait_drained();
        // leave the threshold at its reset value for the directed part
        write_reg(REG_CAPTURE, 16'd1);
    endtask

    task automatic test_directed();
        send_event(OP_X, 16'd0);
        send_event(OP_Y, 16'd65535);
        send_event(OP_OTHER, 16'hFFFF);
        // a change equal to the threshold is not a jump
        send_event(OP_X, 16'd300);
        send_event(OP_Y, 16'd65535);
        send_event(OP_Y, 16'd65235);
        // one above the threshold arms the delayed emit; a repeat releases it
        send_event(OP_X, 16'd601);
        send_event(OP_Y, 16'd65535);
        send_event(OP_Y, 16'd65535);
        send_event(OP_MARK, 16'h5555);
        send_event(OP_X, 16'd65535);
        send_event(OP_Y, 16'd0);
        send_event(OP_MARK, 16'hAAAA);
        send_event(OP_X, 16'd65535);
        set_mode(1'b1, 16'd0);
        send_event(OP_X, 16'd65534);
        send_event(OP_Y, 16'd0);
        send_event(OP_Y, 16'd1);
        send_event(OP_X, 16'd65534);
        set_mode(1'b1, 16'd65535);
        send_event(OP_X, 16'd0);
        send_event(OP_Y, 16'd65535);
        send_event(OP_X, 16'd65535);
        send_event(OP_Y, 16'd0);
    endtask

    task automatic test_threshold_sweep();
        logic [15:0] settings[6];
        settings[0] = THRESH_RESET;
        settings[1] = 16'd0;
        settings[2] = 16'd65535;
        settings[3] = 16'd1;
        settings[4] = 16'($urandom_range(65535));
        settings[5] = 16'($urandom_range(40));
        foreach (settings[i]) begin
            set_mode(1'b1, settings[i]);
            run_random(240);
        end
    endtask

    // Tracking state must survive a stretch with capture off.
    task automatic test_capture_toggle();
        int a;
        set_mode(1'b0, 16'($urandom_range(600)));
        repeat (40) begin
            a = $urandom_range(3);
            send_event(a[1:0], 16'($urandom_range(65535)));
        end
        set_mode(1'b1, thresh);
        run_random(150);
    endtask

    task automatic test_back_to_back();
        set_mode(1'b1, 16'($urandom_range(400)));
        gaps_off = 1'b1;
        run_random(300);
        wait_drained();
        gaps_off = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_threshold_sweep();
        test_capture_toggle();
        test_back_to_back();
        wait_drained();
        if (mismatches == 0 && points_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
